// ===== rtl/pcs_pkg.sv =====
// Shared constants, codes and types of the peer choke selector.
`timescale 1ns / 1ps

package pcs_pkg;

    localparam int PCS_SELECT_COUNT = 4;
    localparam int PCS_QUEUE_DEPTH  = 2;

    localparam int ID_W        = 16;
    localparam int RATE_W      = 32;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    // 50*1024 B/s, and the strict bound 0.1*1024 = 102.4 taken as 103
    localparam logic [RATE_W-1:0] FORCE_UP_RESET   = RATE_W'(50 * 1024);
    localparam logic [RATE_W-1:0] FORCE_DOWN_RESET = RATE_W'(103);

    localparam logic [CFG_INDEX_W-1:0] CFG_FORCE_UP_ABOVE   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_FORCE_DOWN_BELOW = CFG_INDEX_W'(1);

    localparam logic ACT_UNCHOKE = 1'b0;
    localparam logic ACT_CHOKE   = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } pcs_q_stat_t;

endpackage

// ===== rtl/pcs_if.sv =====
// Channel interfaces of the peer choke selector: peer records, decisions, register writes.
`timescale 1ns / 1ps

interface pcs_in_if import pcs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   peer_id;
    logic [RATE_W-1:0] dl_rate;
    logic [RATE_W-1:0] up_rate;
    logic              in_data_state;
    logic              we_are_interested;
    logic              peer_is_seed;
    logic              round_end;

    modport source (
        output valid, peer_id, dl_rate, up_rate, in_data_state,
               we_are_interested, peer_is_seed, round_end,
        input  ready
    );
    modport sink (
        input  valid, peer_id, dl_rate, up_rate, in_data_state,
               we_are_interested, peer_is_seed, round_end,
        output ready
    );
endinterface

interface pcs_out_if import pcs_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] target_peer;
    logic            action;
    logic            last_decision;

    modport source (
        output valid, target_peer, action, last_decision,
        input  ready
    );
    modport sink (
        input  valid, target_peer, action, last_decision,
        output ready
    );
endinterface

interface pcs_cfg_if import pcs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/peer_choke_selector_unit.sv =====
// Top level of the peer choke selector: front end, round queue, decision emitter.
`timescale 1ns / 1ps

// Tit-for-tat choking round, one peer record per word on peer_in.
//   peer_in      : valid/ready records; round_end marks the last record of a round.
//   decision_out : valid/ready words of target_peer, action (0 unchoke, 1 choke)
//                  and last_decision on the final word of a round.
//   cfg          : valid/ready register writes; index 0 sets the upload limit,
//                  index 1 the download floor, other indexes are ignored. cfg.ready
//                  is always high. Write only while no round is in flight.
// Throughput: one record per cycle while the round queue has room, set by the best-set
// update in the front end (parallel compare against all slots). A round produces 0 to
// 2*SELECT_COUNT words, one per cycle from the emitter's output register while
// decision_out is ready. With the emitter idle, the first decision of a round passes
// through the round queue and then the emitter's output register once its round_end
// record is taken. Rounds wait in a two-entry queue, so records of the next round
// keep flowing while decisions drain; peer_in.ready drops only with both entries full.
// A stalled decision_out holds its word; the emitter then waits, and the front
// end keeps running until the queue fills.
// Reset clears the sets, the queue and the output, and restores register defaults.
module peer_choke_selector_unit import pcs_pkg::*; #(
    parameter int SELECT_COUNT = PCS_SELECT_COUNT
) (
    input  logic      clk,
    input  logic      rst_n,
    pcs_in_if.sink    peer_in,
    pcs_out_if.source decision_out,
    pcs_cfg_if.sink   cfg
);

    localparam int CW = $clog2(SELECT_COUNT + 1);

    pcs_q_stat_t q_stat;

    logic                                 q_push;
    logic                                 q_pop;
    logic [SELECT_COUNT-1:0][ID_W-1:0]    push_best_ids;
    logic [CW-1:0]                        push_best_count;
    logic [SELECT_COUNT-1:0][ID_W-1:0]    push_prev_ids;
    logic [SELECT_COUNT-1:0]              push_surv;
    logic [SELECT_COUNT-1:0][ID_W-1:0]    head_best_ids;
    logic [CW-1:0]                        head_best_count;
    logic [SELECT_COUNT-1:0][ID_W-1:0]    head_prev_ids;
    logic [SELECT_COUNT-1:0]              head_surv;

    // Classify records, track the previous and the new set
    pcs_front #(
        .SELECT_COUNT (SELECT_COUNT),
        .CW           (CW)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .peer_in         (peer_in),
        .cfg             (cfg),
        .q_stat          (q_stat),
        .push            (q_push),
        .push_best_ids   (push_best_ids),
        .push_best_count (push_best_count),
        .push_prev_ids   (push_prev_ids),
        .push_surv       (push_surv)
    );

    // Hold finished rounds until the emitter gets to them
    pcs_round_fifo #(
        .SELECT_COUNT (SELECT_COUNT),
        .CW           (CW)
    ) u_fifo (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (q_push),
        .push_best_ids   (push_best_ids),
        .push_best_count (push_best_count),
        .push_prev_ids   (push_prev_ids),
        .push_surv       (push_surv),
        .pop             (q_pop),
        .q_stat          (q_stat),
        .head_best_ids   (head_best_ids),
        .head_best_count (head_best_count),
        .head_prev_ids   (head_prev_ids),
        .head_surv       (head_surv)
    );

    // Drain one round into unchoke words, then choke words
    pcs_back #(
        .SELECT_COUNT (SELECT_COUNT),
        .CW           (CW)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_stat          (q_stat),
        .head_best_ids   (head_best_ids),
        .head_best_count (head_best_count),
        .head_prev_ids   (head_prev_ids),
        .head_surv       (head_surv),
        .pop             (q_pop),
        .decision_out    (decision_out)
    );

    // The front end never pushes a round into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("round pushed into full queue");

    // The emitter never retires a round that is not there
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("round popped from empty queue");

    // A fresh decision word only follows a cycle with a queued round
    a_word_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |=> !(decision_out.valid && !$past(decision_out.valid)))
        else $error("decision word without a queued round");

endmodule

// ===== rtl/pcs_front.sv =====
// Front end: takes peer records, applies force-choke, maintains the best set per round.
`timescale 1ns / 1ps

module pcs_front import pcs_pkg::*; #(
    parameter int SELECT_COUNT = PCS_SELECT_COUNT,
    parameter int CW           = $clog2(SELECT_COUNT + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    pcs_in_if.sink                               peer_in,
    pcs_cfg_if.sink                              cfg,
    input  pcs_q_stat_t                          q_stat,
    output logic                                 push,
    output logic [SELECT_COUNT-1:0][ID_W-1:0]    push_best_ids,
    output logic [CW-1:0]                        push_best_count,
    output logic [SELECT_COUNT-1:0][ID_W-1:0]    push_prev_ids,
    output logic [SELECT_COUNT-1:0]              push_surv
);

    localparam int N  = SELECT_COUNT;
    localparam int IW = (N > 1) ? $clog2(N) : 1;

    logic [RATE_W-1:0] up_thr_reg,   up_thr_next;
    logic [RATE_W-1:0] down_thr_reg, down_thr_next;

    logic [N-1:0][ID_W-1:0]   prev_ids_reg,   prev_ids_next;
    logic [CW-1:0]            prev_count_reg, prev_count_next;
    logic [N-1:0]             seen_reg,       seen_next;
    logic [N-1:0][ID_W-1:0]   best_ids_reg,   best_ids_next;
    logic [N-1:0][RATE_W-1:0] best_rates_reg, best_rates_next;
    logic [CW-1:0]            best_count_reg, best_count_next;

    logic              accept;
    logic [N-1:0]      hit;
    logic              forced;
    logic              cand;
    logic              set_full;
    logic [N-1:0]      is_min;
    logic [RATE_W-1:0] slow_rate;
    logic              replace;

    assign peer_in.ready = !q_stat.full;
    assign cfg.ready     = 1'b1;
    assign accept        = peer_in.valid && peer_in.ready;

    // Register writes
    always_comb
    begin
        up_thr_next   = up_thr_reg;
        down_thr_next = down_thr_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_FORCE_UP_ABOVE:   up_thr_next   = cfg.data;
                CFG_FORCE_DOWN_BELOW: down_thr_next = cfg.data;
                default: ;
            endcase
        end
    end

    // Match against the previous unchoked set
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            hit[i] = (CW'(i) < prev_count_reg) && (prev_ids_reg[i] == peer_in.peer_id);
        end
    end

    assign forced = (|hit) && (peer_in.up_rate > up_thr_reg)
                    && (peer_in.dl_rate < down_thr_reg);
    assign cand   = peer_in.in_data_state && peer_in.we_are_interested
                    && !peer_in.peer_is_seed && !forced;
    assign set_full = (best_count_reg == CW'(N));

    // First slowest slot: strictly below every earlier slot, not above any later one
    always_comb
    begin
        logic ok;
        for (int i = 0; i < N; i++)
        begin
            ok = 1'b1;
            for (int j = 0; j < N; j++)
            begin
                if (j < i && !(best_rates_reg[i] < best_rates_reg[j]))
                    ok = 1'b0;
                if (j > i && !(best_rates_reg[i] <= best_rates_reg[j]))
                    ok = 1'b0;
            end
            is_min[i] = ok;
        end
    end

    always_comb
    begin
        slow_rate = '0;
        for (int i = 0; i < N; i++)
        begin
            if (is_min[i])
                slow_rate = slow_rate | best_rates_reg[i];
        end
    end

    assign replace = (peer_in.dl_rate >= slow_rate);

    // Best set update
    always_comb
    begin
        best_ids_next   = best_ids_reg;
        best_rates_next = best_rates_reg;
        best_count_next = best_count_reg;
        if (accept && cand)
        begin
            if (!set_full)
            begin
                best_ids_next[best_count_reg[IW-1:0]]   = peer_in.peer_id;
                best_rates_next[best_count_reg[IW-1:0]] = peer_in.dl_rate;
                best_count_next = best_count_reg + CW'(1);
            end
            else if (replace)
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (is_min[i])
                    begin
                        best_ids_next[i]   = peer_in.peer_id;
                        best_rates_next[i] = peer_in.dl_rate;
                    end
                end
            end
        end
    end

    assign seen_next = seen_reg | (accept ? hit : '0);

    // Hand the finished round to the queue
    assign push            = accept && peer_in.round_end;
    assign push_best_ids   = best_ids_next;
    assign push_best_count = best_count_next;
    assign push_prev_ids   = prev_ids_reg;
    assign push_surv       = seen_next;

    assign prev_ids_next   = push ? best_ids_next   : prev_ids_reg;
    assign prev_count_next = push ? best_count_next : prev_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_thr_reg     <= FORCE_UP_RESET;
            down_thr_reg   <= FORCE_DOWN_RESET;
            prev_count_reg <= '0;
            best_count_reg <= '0;
            seen_reg       <= '0;
        end
        else
        begin
            up_thr_reg     <= up_thr_next;
            down_thr_reg   <= down_thr_next;
            prev_count_reg <= prev_count_next;
            best_count_reg <= push ? '0 : best_count_next;
            seen_reg       <= push ? '0 : seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_ids_reg   <= prev_ids_next;
        best_ids_reg   <= best_ids_next;
        best_rates_reg <= best_rates_next;
    end

endmodule

// ===== rtl/pcs_round_fifo.sv =====
// Short queue of finished rounds between the front end and the decision emitter.
`timescale 1ns / 1ps

module pcs_round_fifo import pcs_pkg::*; #(
    parameter int SELECT_COUNT = PCS_SELECT_COUNT,
    parameter int CW           = $clog2(SELECT_COUNT + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic [SELECT_COUNT-1:0][ID_W-1:0]    push_best_ids,
    input  logic [CW-1:0]                        push_best_count,
    input  logic [SELECT_COUNT-1:0][ID_W-1:0]    push_prev_ids,
    input  logic [SELECT_COUNT-1:0]              push_surv,
    input  logic                                 pop,
    output pcs_q_stat_t                          q_stat,
    output logic [SELECT_COUNT-1:0][ID_W-1:0]    head_best_ids,
    output logic [CW-1:0]                        head_best_count,
    output logic [SELECT_COUNT-1:0][ID_W-1:0]    head_prev_ids,
    output logic [SELECT_COUNT-1:0]              head_surv
);

    localparam int N     = SELECT_COUNT;
    localparam int DEPTH = PCS_QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW    = $clog2(DEPTH + 1);

    logic [N-1:0][ID_W-1:0] q_best_ids   [DEPTH];
    logic [CW-1:0]          q_best_count [DEPTH];
    logic [N-1:0][ID_W-1:0] q_prev_ids   [DEPTH];
    logic [N-1:0]           q_surv       [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QW-1:0] fill_reg,   fill_next;

    logic do_push, do_pop;

    assign q_stat.full  = (fill_reg == QW'(DEPTH));
    assign q_stat.empty = (fill_reg == '0);

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    assign wr_ptr_next = !do_push ? wr_ptr_reg
                       : (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
    assign rd_ptr_next = !do_pop ? rd_ptr_reg
                       : (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + QW'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - QW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_best_ids[wr_ptr_reg]   <= push_best_ids;
            q_best_count[wr_ptr_reg] <= push_best_count;
            q_prev_ids[wr_ptr_reg]   <= push_prev_ids;
            q_surv[wr_ptr_reg]       <= push_surv;
        end
    end

    assign head_best_ids   = q_best_ids[rd_ptr_reg];
    assign head_best_count = q_best_count[rd_ptr_reg];
    assign head_prev_ids   = q_prev_ids[rd_ptr_reg];
    assign head_surv       = q_surv[rd_ptr_reg];

endmodule

// ===== rtl/pcs_back.sv =====
// Back end: turns a queued round into unchoke then choke decision words.
`timescale 1ns / 1ps

module pcs_back import pcs_pkg::*; #(
    parameter int SELECT_COUNT = PCS_SELECT_COUNT,
    parameter int CW           = $clog2(SELECT_COUNT + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pcs_q_stat_t                          q_stat,
    input  logic [SELECT_COUNT-1:0][ID_W-1:0]    head_best_ids,
    input  logic [CW-1:0]                        head_best_count,
    input  logic [SELECT_COUNT-1:0][ID_W-1:0]    head_prev_ids,
    input  logic [SELECT_COUNT-1:0]              head_surv,
    output logic                                 pop,
    pcs_out_if.source                            decision_out
);

    localparam int N = SELECT_COUNT;
    localparam int M = 2 * SELECT_COUNT;

    logic [M-1:0] done_reg, done_next;
    logic         out_valid_reg, out_valid_next;
    logic [ID_W-1:0] out_id_reg;
    logic         out_action_reg;
    logic         out_last_reg;

    logic [N-1:0] unch_flag;
    logic [N-1:0] choke_flag;
    logic [M-1:0] mask;
    logic [M-1:0] pick;
    logic [M-1:0] rest;
    logic [M-1:0][ID_W-1:0] all_ids;
    logic [ID_W-1:0] pick_id;
    logic         pick_choke;
    logic         pick_last;
    logic         has_work;
    logic         slot_free;
    logic         emit;

    // Unchoke: new entries not among survivors. Choke: survivors not in the new set.
    always_comb
    begin
        logic found;
        for (int i = 0; i < N; i++)
        begin
            found = 1'b0;
            for (int j = 0; j < N; j++)
            begin
                if (head_surv[j] && (head_prev_ids[j] == head_best_ids[i]))
                    found = 1'b1;
            end
            unch_flag[i] = (CW'(i) < head_best_count) && !found;
        end
        for (int j = 0; j < N; j++)
        begin
            found = 1'b0;
            for (int i = 0; i < N; i++)
            begin
                if ((CW'(i) < head_best_count) && (head_best_ids[i] == head_prev_ids[j]))
                    found = 1'b1;
            end
            choke_flag[j] = head_surv[j] && !found;
        end
    end

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            all_ids[k]     = head_best_ids[k];
            all_ids[k + N] = head_prev_ids[k];
        end
    end

    assign mask = {choke_flag, unch_flag} & ~done_reg;
    assign pick = mask & ((~mask) + M'(1));
    assign rest = mask & ~pick;

    always_comb
    begin
        pick_id = '0;
        for (int k = 0; k < M; k++)
        begin
            if (pick[k])
                pick_id = pick_id | all_ids[k];
        end
    end

    assign pick_choke = |pick[M-1:N];
    assign pick_last  = (rest == '0);

    assign has_work  = !q_stat.empty && (mask != '0);
    assign slot_free = !out_valid_reg || decision_out.ready;
    assign emit      = has_work && slot_free;

    // Drop a round with nothing to say at once; otherwise when its final word is emitted
    assign pop = (!q_stat.empty && (mask == '0)) || (emit && pick_last);

    always_comb
    begin
        done_next = done_reg;
        if (pop)
            done_next = '0;
        else if (emit)
            done_next = done_reg | pick;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (decision_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_id_reg     <= pick_id;
            out_action_reg <= pick_choke ? ACT_CHOKE : ACT_UNCHOKE;
            out_last_reg   <= pick_last;
        end
    end

    assign decision_out.valid         = out_valid_reg;
    assign decision_out.target_peer   = out_id_reg;
    assign decision_out.action        = out_action_reg;
    assign decision_out.last_decision = out_last_reg;

endmodule

// ===== bench/pcs_checker.sv =====
// Scoreboard for the peer choke selector: models choking rounds and checks each decision word.
`timescale 1ns / 1ps

module pcs_checker import pcs_pkg::*; #(
    parameter int SELECT_COUNT = PCS_SELECT_COUNT
) (
    input  logic clk,
    input  logic rst_n,
    pcs_in_if    peer_mon,
    pcs_out_if   decision_mon,
    pcs_cfg_if   cfg_mon,
    output int   mismatches,
    output int   pending
);

    typedef struct packed {
        logic [ID_W-1:0] peer;
        logic            action;
        logic            last;
    } decision_t;

    decision_t decisions_due[$];

    logic [RATE_W-1:0] up_limit;
    logic [RATE_W-1:0] down_floor;

    logic [ID_W-1:0]   unchoked_ids [SELECT_COUNT];
    int                unchoked_count;
    logic [ID_W-1:0]   leader_ids   [SELECT_COUNT];
    logic [RATE_W-1:0] leader_rates [SELECT_COUNT];
    int                leader_count;
    logic [SELECT_COUNT-1:0] named_mask;

    int word_index;

    initial
    begin
        mismatches = 0;
        pending    = 0;
        word_index = 0;
    end

    // Update the round state with one peer record; on the last record of a
    // round, queue its unchokes and then its chokes.
    task automatic take_record(
        input logic [ID_W-1:0]   id,
        input logic [RATE_W-1:0] down,
        input logic [RATE_W-1:0] up,
        input logic              data,
        input logic              interested,
        input logic              seed,
        input logic              closes_round
    );
        int        i;
        int        j;
        int        n;
        int        slow;
        logic      was_unchoked;
        logic      forced;
        logic      hit;
        decision_t batch [2*SELECT_COUNT];

        was_unchoked = 1'b0;
        n = 0;
        for (i = 0; i < unchoked_count; i++)
        begin
            if (unchoked_ids[i] == id)
            begin
                named_mask[i] = 1'b1;
                was_unchoked  = 1'b1;
            end
        end
        forced = was_unchoked && (up > up_limit) && (down < down_floor);

        if (data && interested && !seed && !forced)
        begin
            if (leader_count < SELECT_COUNT)
            begin
                leader_ids[leader_count]   = id;
                leader_rates[leader_count] = down;
                leader_count++;
            end
            else
            begin
                slow = 0;
                for (i = 1; i < SELECT_COUNT; i++)
                    if (leader_rates[i] < leader_rates[slow])
                        slow = i;
                if (down >= leader_rates[slow])
                begin
                    leader_ids[slow]   = id;
                    leader_rates[slow] = down;
                end
            end
        end

        if (closes_round)
        begin
            for (i = 0; i < leader_count; i++)
            begin
                hit = 1'b0;
                for (j = 0; j < unchoked_count; j++)
                    if (named_mask[j] && unchoked_ids[j] == leader_ids[i])
                        hit = 1'b1;
                if (!hit)
                begin
                    batch[n] = '{peer: leader_ids[i], action: ACT_UNCHOKE, last: 1'b0};
                    n++;
                end
            end
            for (j = 0; j < unchoked_count; j++)
            begin
                hit = 1'b0;
                for (i = 0; i < leader_count; i++)
                    if (leader_ids[i] == unchoked_ids[j])
                        hit = 1'b1;
                if (named_mask[j] && !hit)
                begin
                    batch[n] = '{peer: unchoked_ids[j], action: ACT_CHOKE, last: 1'b0};
                    n++;
                end
            end
            for (i = 0; i < n; i++)
            begin
                batch[i].last = (i == n - 1);
                decisions_due.push_back(batch[i]);
            end
            for (i = 0; i < SELECT_COUNT; i++)
                unchoked_ids[i] = leader_ids[i];
            unchoked_count = leader_count;
            leader_count   = 0;
            named_mask     = '0;
        end
    endtask

    task automatic check_word(
        input logic [ID_W-1:0] peer,
        input logic            action,
        input logic            last
    );
        decision_t due;

        if (decisions_due.size() == 0)
        begin
            $display("%0t: decision word %0d unexpected: peer %h action %b last %b",
                     $time, word_index, peer, action, last);
            mismatches++;
        end
        else
        begin
            due = decisions_due.pop_front();
            if (peer !== due.peer)
            begin
                $display("%0t: word %0d target_peer expected %h actual %h",
                         $time, word_index, due.peer, peer);
                mismatches++;
            end
            if (action !== due.action)
            begin
                $display("%0t: word %0d action expected %b actual %b",
                         $time, word_index, due.action, action);
                mismatches++;
            end
            if (last !== due.last)
            begin
                $display("%0t: word %0d last_decision expected %b actual %b",
                         $time, word_index, due.last, last);
                mismatches++;
            end
        end
        word_index++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decisions_due.delete();
            up_limit       = FORCE_UP_RESET;
            down_floor     = FORCE_DOWN_RESET;
            unchoked_count = 0;
            leader_count   = 0;
            named_mask     = '0;
        end
        else
        begin
            if (decision_mon.valid && decision_mon.ready)
                check_word(decision_mon.target_peer, decision_mon.action,
                           decision_mon.last_decision);
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                if (cfg_mon.index == CFG_FORCE_UP_ABOVE)
                    up_limit = cfg_mon.data;
                else if (cfg_mon.index == CFG_FORCE_DOWN_BELOW)
                    down_floor = cfg_mon.data;
            end
            if (peer_mon.valid && peer_mon.ready)
                take_record(peer_mon.peer_id, peer_mon.dl_rate, peer_mon.up_rate,
                            peer_mon.in_data_state, peer_mon.we_are_interested,
                            peer_mon.peer_is_seed, peer_mon.round_end);
        end
        pending = decisions_due.size();
    end

endmodule

// ===== bench/peer_choke_selector_unit_tb.sv =====
// Testbench top for the peer choke selector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module peer_choke_selector_unit_tb;
    import pcs_pkg::*;

    // Hard stop: far above the slowest legal run (every round at eight words,
    // every word held through the longest stall, every record after a long gap).
    localparam int CYCLE_LIMIT   = 500000;
    // Zero-word rounds can still sit in the round queue when nothing is due;
    // the settle wait leaves them time to go, with margin.
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASE_ITEMS   = 52;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = CFG_INDEX_W'(15);
    localparam int POOL_SIZE     = 12;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   chk_mismatches;
    int   chk_pending;

    // Thresholds as currently programmed, used only to aim rates at the edges.
    logic [RATE_W-1:0] up_aim;
    logic [RATE_W-1:0] down_aim;

    // Small id pool so that peers come back round after round and reach the
    // survivor, stale and force-choke paths.
    logic [ID_W-1:0] id_pool [POOL_SIZE];

    pcs_in_if  peer_in ();
    pcs_out_if decision_out ();
    pcs_cfg_if cfg ();

    peer_choke_selector_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .peer_in      (peer_in),
        .decision_out (decision_out),
        .cfg          (cfg)
    );

    pcs_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .peer_mon     (peer_in),
        .decision_mon (decision_out),
        .cfg_mon      (cfg),
        .mismatches   (chk_mismatches),
        .pending      (chk_pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort on a hung handshake or a block that never drains.
    initial
        cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Gap before a record: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;

        roll = $urandom_range(0, 19);
        if (roll < 9)
            return 0;
        else if (roll < 18)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Rate aimed at a threshold: the extremes, one below, at, one above, or random.
    function automatic logic [RATE_W-1:0] pick_rate(input logic [RATE_W-1:0] aim);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return aim - 1;
            3: return aim;
            4: return aim + 1;
            5: return RATE_W'($urandom_range(0, 255));
            default: return RATE_W'($urandom);
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 19) < 17)
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            return ID_W'($urandom);
    endfunction

    // Present one record at the falling edge, hold it until taken, and leave
    // valid high so back-to-back words need no extra edge.
    task automatic send_record(
        input logic [ID_W-1:0]   id,
        input logic [RATE_W-1:0] down,
        input logic [RATE_W-1:0] up,
        input logic              data,
        input logic              interested,
        input logic              seed,
        input logic              closes_round,
        input int                gap
    );
        if (gap > 0)
        begin
            peer_in.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        peer_in.peer_id           = id;
        peer_in.dl_rate           = down;
        peer_in.up_rate           = up;
        peer_in.in_data_state     = data;
        peer_in.we_are_interested = interested;
        peer_in.peer_is_seed      = seed;
        peer_in.round_end         = closes_round;
        peer_in.valid             = 1'b1;
        @(posedge clk);
        while (!peer_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Eligible record with a random gap; the common case in the directed part.
    task automatic send_eligible(
        input logic [ID_W-1:0]   id,
        input logic [RATE_W-1:0] down,
        input logic [RATE_W-1:0] up,
        input logic              closes_round
    );
        send_record(id, down, up, 1'b1, 1'b1, 1'b0, closes_round, pick_gap());
    endtask

    task automatic write_reg(
        input logic [CFG_INDEX_W-1:0] index,
        input logic [CFG_DATA_W-1:0]  value
    );
        cfg.index = index;
        cfg.data  = value;
        cfg.valid = 1'b1;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // Drop valid, wait out every due word, then let trailing zero-word rounds
    // leave the queue.
    task automatic settle();
        peer_in.valid = 1'b0;
        while (chk_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_limits(
        input logic [RATE_W-1:0] up_limit,
        input logic [RATE_W-1:0] down_floor
    );
        settle();
        write_reg(CFG_FORCE_UP_ABOVE, up_limit);
        write_reg(CFG_FORCE_DOWN_BELOW, down_floor);
        up_aim   = up_limit;
        down_aim = down_floor;
    endtask

    // Rounds of random length; most records are eligible, the rest carry
    // random flags. Some rounds run with no gaps at all.
    task automatic random_rounds(input int item_total);
        int   sent;
        int   span;
        int   k;
        logic steady;
        logic data;
        logic interested;
        logic seed;

        sent = 0;
        while (sent < item_total)
        begin
            span = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            if (span > item_total - sent)
                span = item_total - sent;
            steady = ($urandom_range(0, 4) == 0);
            for (k = 0; k < span; k++)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    data       = 1'b1;
                    interested = 1'b1;
                    seed       = 1'b0;
                end
                else
                begin
                    data       = 1'($urandom_range(0, 1));
                    interested = 1'($urandom_range(0, 1));
                    seed       = 1'($urandom_range(0, 1));
                end
                send_record(pick_id(), pick_rate(down_aim), pick_rate(up_aim),
                            data, interested, seed, k == span - 1,
                            steady ? 0 : pick_gap());
            end
            sent += span;
        end
    endtask

    // Decision sink: ready bursts and stalls of random length, a few long ones
    // each way so stalls land on every word of a round.
    initial
    begin
        int burst;
        int stall;

        decision_out.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
            decision_out.ready = 1'b1;
            repeat (burst) @(negedge clk);
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
            decision_out.ready = 1'b0;
            repeat (stall) @(negedge clk);
        end
    end

    initial
    begin
        int i;

        // Hold every input at a known value from time zero.
        rst_n                     = 1'b0;
        peer_in.valid             = 1'b0;
        peer_in.peer_id           = '0;
        peer_in.dl_rate           = '0;
        peer_in.up_rate           = '0;
        peer_in.in_data_state     = 1'b0;
        peer_in.we_are_interested = 1'b0;
        peer_in.peer_is_seed      = 1'b0;
        peer_in.round_end         = 1'b0;
        cfg.valid                 = 1'b0;
        cfg.index                 = '0;
        cfg.data                  = '0;
        up_aim                    = FORCE_UP_RESET;
        down_aim                  = FORCE_DOWN_RESET;

        id_pool[0] = '0;
        id_pool[1] = '1;
        for (i = 2; i < POOL_SIZE; i++)
            id_pool[i] = ID_W'($urandom);

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Round one, from an empty set, register defaults: id and rate
        // extremes, one record per ineligible flag, then a full set where an
        // equal rate replaces the first slowest slot.
        send_eligible(ID_W'(0), RATE_W'(0), RATE_W'(0), 1'b0);
        send_eligible('1, '1, '1, 1'b0);
        send_record(ID_W'(10), RATE_W'(500), RATE_W'(0), 1'b0, 1'b1, 1'b0, 1'b0, pick_gap());
        send_record(ID_W'(11), RATE_W'(500), RATE_W'(0), 1'b1, 1'b0, 1'b0, 1'b0, pick_gap());
        send_record(ID_W'(12), RATE_W'(500), RATE_W'(0), 1'b1, 1'b1, 1'b1, 1'b0, pick_gap());
        send_eligible(ID_W'(20), RATE_W'(1000), RATE_W'(0), 1'b0);
        send_eligible(ID_W'(21), RATE_W'(1000), RATE_W'(0), 1'b0);
        send_eligible(ID_W'(22), RATE_W'(0), RATE_W'(0), 1'b0);
        send_eligible(ID_W'(23), RATE_W'(5), RATE_W'(0), 1'b1);

        // Round two: force-choke a former peer, keep two on the bounds of the
        // limits, leave one out as stale, repeat an id, and push a survivor out.
        send_eligible('1, RATE_W'(50), RATE_W'(60000), 1'b0);
        send_eligible(ID_W'(20), FORCE_DOWN_RESET - 1, FORCE_UP_RESET, 1'b0);
        send_eligible(ID_W'(21), FORCE_DOWN_RESET, RATE_W'(70000), 1'b0);
        send_eligible(ID_W'(30), RATE_W'(2000), RATE_W'(0), 1'b0);
        send_eligible(ID_W'(30), RATE_W'(2000), RATE_W'(0), 1'b0);
        send_eligible(ID_W'(31), FORCE_DOWN_RESET, RATE_W'(0), 1'b1);

        // Round three yields no word: every former peer is stale and the only
        // record is ineligible. Round four then starts from an empty set.
        send_record(ID_W'(40), RATE_W'(9), RATE_W'(0), 1'b0, 1'b0, 1'b0, 1'b1, pick_gap());
        send_eligible(ID_W'(41), RATE_W'(7), RATE_W'(0), 1'b1);

        // Random phases, each under its own pair of limits.
        program_limits('0, '1);
        random_rounds(PHASE_ITEMS);

        program_limits('1, '0);
        write_reg(CFG_UNUSED_INDEX, $urandom);
        random_rounds(PHASE_ITEMS);

        program_limits(RATE_W'($urandom), RATE_W'($urandom));
        random_rounds(PHASE_ITEMS);

        program_limits(RATE_W'($urandom_range(0, 1000)), RATE_W'($urandom_range(0, 1000)));
        random_rounds(PHASE_ITEMS);

        program_limits(FORCE_UP_RESET, FORCE_DOWN_RESET);
        random_rounds(PHASE_ITEMS);

        // Drain and give the verdict.
        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (chk_mismatches == 0 && chk_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== peer_choke_selector_unit.f =====
rtl/pcs_pkg.sv
rtl/pcs_if.sv
rtl/pcs_front.sv
rtl/pcs_round_fifo.sv
rtl/pcs_back.sv
rtl/peer_choke_selector_unit.sv
bench/pcs_checker.sv
bench/peer_choke_selector_unit_tb.sv
